/* src/kmd_pkg.sv */
// ----------------------------------------------------------------------------
// kmd_pkg
// shared constants, register indexes and types of the key matrix debouncer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package kmd_pkg;

  localparam int ROWS_DEF   = 8;
  localparam int COLS_DEF   = 16;
  localparam int DEBOUNCE   = 5;

  localparam int ROW_W      = 3;
  localparam int COL_W      = 16;
  localparam int CNT_W      = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_RELOAD   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_GHOST_EN = CFG_IDX_W'(1);

  typedef struct packed {
    logic [CNT_W-1:0] reload;
    logic             ghost_en;
  } kmd_cfg_t;

  typedef struct packed {
    logic [COL_W-1:0] stable_row;
    logic             settled;
    logic             bounce_seen;
    logic             ghost;
  } kmd_result_t;

  function automatic logic [COL_W-1:0] col_mask(input int cols);
    logic [31:0] m;
    m = 32'd0;
    if (cols >= COL_W) begin
      return '1;
    end
    m = (32'd1 << cols) - 32'd1;
    return m[COL_W-1:0];
  endfunction

endpackage

/* src/kmd_if.sv */
// ----------------------------------------------------------------------------
// kmd interfaces
// valid/ready channels for sample words, result words and register writes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface kmd_item_if;
  logic                       valid;
  logic                       ready;
  logic [kmd_pkg::ROW_W-1:0]  row_index;
  logic [kmd_pkg::COL_W-1:0]  column_sample;
  logic                       scan_end;

  modport source (output valid, output row_index, output column_sample,
                  output scan_end, input ready);
  modport sink   (input valid, input row_index, input column_sample,
                  input scan_end, output ready);
endinterface

interface kmd_result_if;
  logic                       valid;
  logic                       ready;
  logic [kmd_pkg::COL_W-1:0]  stable_row;
  logic                       settled;
  logic                       bounce_seen;
  logic                       ghost;

  modport source (output valid, output stable_row, output settled,
                  output bounce_seen, output ghost, input ready);
  modport sink   (input valid, input stable_row, input settled,
                  input bounce_seen, input ghost, output ready);
endinterface

interface kmd_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [kmd_pkg::CFG_IDX_W-1:0]   index;
  logic [kmd_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* src/kmd_row_store.sv */
// ----------------------------------------------------------------------------
// kmd_row_store
// one-write one-read row memory, registered read, per-row valid bits
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kmd_row_store #(
  parameter int DEPTH = 8,
  parameter int AW    = 3,
  parameter int DW    = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vld;
  logic [DW-1:0] rd_q;
  logic          rd_vld;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (we) begin
        vld[waddr] <= 1'b1;
      end
      rd_vld <= vld[raddr];
    end
  end

  // unwritten rows read as zero
  assign rdata = rd_vld ? rd_q : '0;

endmodule

/* src/kmd_seq.sv */
// ----------------------------------------------------------------------------
// kmd_seq
// per-word sequencer: raw row compare and write back, countdown, copy sweep
// of raw rows into stable rows, ghost sweep over stable rows
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kmd_seq #(
  parameter int ROWS = kmd_pkg::ROWS_DEF,
  parameter int COLS = kmd_pkg::COLS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  kmd_item_if.sink           item,
  input  kmd_pkg::kmd_cfg_t  cfg,
  output logic               res_valid,
  output kmd_pkg::kmd_result_t res,
  input  logic               res_take
);
  import kmd_pkg::*;

  localparam int AW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CW = $clog2(ROWS + 1);
  localparam logic [COL_W-1:0] COL_MASK = col_mask(COLS);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CMP   = 3'd1;
  localparam logic [2:0] S_COPY  = 3'd2;
  localparam logic [2:0] S_GHOST = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]       state;
  logic [AW-1:0]    row;
  logic             row_ok;
  logic [COL_W-1:0] sample;
  logic             end_flag;
  logic             bounce;
  logic [CNT_W-1:0] countdown;
  logic [CW-1:0]    cnt;
  logic [COL_W-1:0] own_row;
  logic [COL_W-1:0] others;

  logic             raw_we;
  logic [AW-1:0]    raw_raddr;
  logic [COL_W-1:0] raw_rdata;
  logic             stb_we;
  logic [AW-1:0]    stb_addr;
  logic [COL_W-1:0] stb_rdata;

  logic             in_row_ok;
  logic [AW-1:0]    in_row;
  logic             bounce_next;
  logic [CNT_W-1:0] reload_eff;
  logic [CNT_W-1:0] cd_a;
  logic [CNT_W-1:0] countdown_next;
  logic             copy_next;
  logic [CW-1:0]    cnt_prev;
  logic             cnt_last;

  assign item.ready = (state == S_IDLE);

  assign in_row_ok = (32'(item.row_index) < ROWS);
  assign in_row    = in_row_ok ? AW'(item.row_index) : '0;

  assign cnt_prev = cnt - CW'(1);
  assign cnt_last = (32'(cnt) == ROWS);

  assign reload_eff  = (cfg.reload == '0) ? CNT_W'(1) : cfg.reload;
  assign bounce_next = row_ok && (raw_rdata != sample);
  assign cd_a        = bounce_next ? reload_eff : countdown;

  always_comb begin
    countdown_next = cd_a;
    copy_next      = 1'b0;
    if (end_flag && (cd_a != '0)) begin
      countdown_next = cd_a - CNT_W'(1);
      copy_next      = (cd_a == CNT_W'(1));
    end
  end

  assign raw_we    = (state == S_CMP) && bounce_next;
  assign raw_raddr = (state == S_IDLE) ? in_row : cnt[AW-1:0];
  assign stb_we    = (state == S_COPY) && (cnt != '0);
  assign stb_addr  = (state == S_COPY) ? cnt_prev[AW-1:0] : cnt[AW-1:0];

  kmd_row_store #(.DEPTH(ROWS), .AW(AW), .DW(COL_W)) u_raw (
    .clk   (clk),
    .rst   (rst),
    .we    (raw_we),
    .waddr (row),
    .wdata (sample),
    .raddr (raw_raddr),
    .rdata (raw_rdata)
  );

  kmd_row_store #(.DEPTH(ROWS), .AW(AW), .DW(COL_W)) u_stable (
    .clk   (clk),
    .rst   (rst),
    .we    (stb_we),
    .waddr (stb_addr),
    .wdata (raw_rdata),
    .raddr (stb_addr),
    .rdata (stb_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      countdown <= CNT_W'(DEBOUNCE);
      cnt       <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (item.valid) begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          countdown <= countdown_next;
          cnt       <= '0;
          state     <= copy_next ? S_COPY : S_GHOST;
        end
        S_COPY: begin
          if (cnt_last) begin
            cnt   <= '0;
            state <= S_GHOST;
          end else begin
            cnt <= cnt + CW'(1);
          end
        end
        S_GHOST: begin
          if (cnt_last) begin
            state <= S_DONE;
          end else begin
            cnt <= cnt + CW'(1);
          end
        end
        S_DONE: begin
          if (res_take) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // item payload and sweep accumulators
  always_ff @(posedge clk) begin
    if (state == S_IDLE && item.valid) begin
      row      <= in_row;
      row_ok   <= in_row_ok;
      sample   <= item.column_sample & COL_MASK;
      end_flag <= item.scan_end;
    end
    if (state == S_CMP) begin
      bounce  <= bounce_next;
      own_row <= '0;
      others  <= '0;
    end
    if (state == S_GHOST && cnt != '0) begin
      if (cnt_prev[AW-1:0] == row) begin
        own_row <= stb_rdata;
      end else begin
        others <= others | stb_rdata;
      end
    end
  end

  assign res_valid       = (state == S_DONE);
  assign res.stable_row  = row_ok ? own_row : '0;
  assign res.settled     = (countdown == '0);
  assign res.bounce_seen = bounce;
  assign res.ghost       = cfg.ghost_en && row_ok
                           && ((own_row & (own_row - COL_W'(1))) != '0)
                           && ((own_row & others) != '0);

endmodule

/* src/key_matrix_debounce_unit.sv */
// ----------------------------------------------------------------------------
// key_matrix_debounce_unit
// sequence: a taken word is compared, raw rows are copied to stable rows when
//   the countdown expires, then the ghost sweep runs and the result is registered
// a new word is taken only after the last result has left the sequencer,
//   after its row-by-row sweeps through the single read port of the row memories
// reset: raw and stable rows read as zero, countdown 5, reload 5, ghost off
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module key_matrix_debounce_unit #(
  parameter int ROWS = kmd_pkg::ROWS_DEF,
  parameter int COLS = kmd_pkg::COLS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  kmd_cfg_if.sink     cfg,
  kmd_item_if.sink    item,
  kmd_result_if.source result
);
  import kmd_pkg::*;

  kmd_cfg_t    cfg_regs;
  logic        res_valid;
  kmd_result_t res;
  logic        res_take;
  logic        out_valid;
  kmd_result_t out_word;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.reload   <= CNT_W'(DEBOUNCE);
      cfg_regs.ghost_en <= 1'b0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_RELOAD:   cfg_regs.reload   <= cfg.data[CNT_W-1:0];
        REG_GHOST_EN: cfg_regs.ghost_en <= cfg.data[0];
        default: begin
        end
      endcase
    end
  end

  kmd_seq #(.ROWS(ROWS), .COLS(COLS)) u_seq (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .cfg       (cfg_regs),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (res_take)
  );

  // output word register
  assign res_take = res_valid && (!out_valid || result.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_word <= res;
    end
  end

  assign result.valid       = out_valid;
  assign result.stable_row  = out_word.stable_row;
  assign result.settled     = out_word.settled;
  assign result.bounce_seen = out_word.bounce_seen;
  assign result.ghost       = out_word.ghost;

endmodule

/* tb/key_matrix_debounce_unit_test.sv */
// ----------------------------------------------------------------------------
// key_matrix_debounce_unit_test
// Checks the key matrix debouncer word by word. Row scans with
// slowly changing key patterns, contact bounce and stray words go in through
// the item channel. A scoreboard keeps its own raw and stable matrices, the
// countdown and the register values, and compares every result field in
// order. The run steps through several reload and ghost settings, stalls
// both channels at random and holds the result side off long enough to
// back the block up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module key_matrix_debounce_unit_test;
  import kmd_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);
  localparam int HOLD_CYCLES = 300;

  class debounce_scoreboard;
    logic [COL_W-1:0] raw_rows [ROWS_DEF];
    logic [COL_W-1:0] stable_rows [ROWS_DEF];
    logic [CNT_W-1:0] countdown;
    logic [CNT_W-1:0] reload;
    logic             ghost_en;
    kmd_result_t      due_results [$];
    int errors, words, settles, bounces, ghosts, reg_writes;

    function new();
      foreach (raw_rows[i]) begin
        raw_rows[i] = '0;
        stable_rows[i] = '0;
      end
      countdown = CNT_W'(DEBOUNCE);
      reload = CNT_W'(DEBOUNCE);
      ghost_en = 1'b0;
      errors = 0;
      words = 0;
      settles = 0;
      bounces = 0;
      ghosts = 0;
      reg_writes = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      reg_writes++;
      case (idx)
        REG_RELOAD: begin
          reload = data;
        end
        REG_GHOST_EN: begin
          ghost_en = data[0];
        end
        default: begin
        end
      endcase
    endfunction

    // two or more keys down and a column shared with another stable row
    function bit ghost_in_row(int r);
      logic [COL_W-1:0] v;
      bit hit;
      v = stable_rows[r];
      hit = 1'b0;
      if ($countones(v) < 2) return 1'b0;
      for (int i = 0; i < ROWS_DEF; i++) begin
        if (i != r && (stable_rows[i] & v) != '0) hit = 1'b1;
      end
      return hit;
    endfunction

    function void note_word(logic [ROW_W-1:0] row, logic [COL_W-1:0] sample,
                            logic scan_end);
      kmd_result_t exp;
      exp = '0;
      if (raw_rows[row] != sample) begin
        raw_rows[row] = sample;
        exp.bounce_seen = 1'b1;
        countdown = (reload == '0) ? CNT_W'(1) : reload;
        bounces++;
      end
      if (scan_end && countdown != '0) begin
        countdown = countdown - 1'b1;
        if (countdown == '0) begin
          foreach (stable_rows[i]) stable_rows[i] = raw_rows[i];
          settles++;
        end
      end
      exp.stable_row = stable_rows[row];
      exp.settled = (countdown == '0);
      exp.ghost = ghost_en && ghost_in_row(int'(row));
      if (exp.ghost) ghosts++;
      words++;
      due_results.push_back(exp);
    endfunction

    function void check_word(kmd_result_t got);
      kmd_result_t exp;
      if (due_results.size() == 0) begin
        errors++;
        $display("%0t: result word with nothing due, expected none, actual %h", $time, got);
        return;
      end
      exp = due_results.pop_front();
      if (got.stable_row !== exp.stable_row) begin
        errors++;
        $display("%0t: stable_row expected %h actual %h", $time, exp.stable_row,
                 got.stable_row);
      end
      if (got.settled !== exp.settled) begin
        errors++;
        $display("%0t: settled expected %b actual %b", $time, exp.settled, got.settled);
      end
      if (got.bounce_seen !== exp.bounce_seen) begin
        errors++;
        $display("%0t: bounce_seen expected %b actual %b", $time, exp.bounce_seen,
                 got.bounce_seen);
      end
      if (got.ghost !== exp.ghost) begin
        errors++;
        $display("%0t: ghost expected %b actual %b", $time, exp.ghost, got.ghost);
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  kmd_cfg_if    cfg_ch ();
  kmd_item_if   item_ch ();
  kmd_result_if result_ch ();

  debounce_scoreboard sb = new();

  int               idle_pct;
  bit               stall_on;
  bit               rx_hold_req;
  logic [COL_W-1:0] keys [ROWS_DEF];

  key_matrix_debounce_unit DUT (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_ch),
    .item   (item_ch),
    .result (result_ch)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  initial begin
    #5_000_000;
    $display("key_matrix_debounce_unit_test: errors");
    $finish;
  end

  // result side: random stalls plus one long hold-off on request
  initial begin : result_sink
    int stall_left;
    int hold_left;
    bit hold_done;
    stall_left = 0;
    hold_left = 0;
    hold_done = 1'b0;
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_req && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        result_ch.ready = 1'b0;
      end else if (stall_on && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 18) - 1;
        result_ch.ready = 1'b0;
      end else begin
        result_ch.ready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin : result_watch
    kmd_result_t got;
    if (!rst && result_ch.valid && result_ch.ready) begin
      got.stable_row = result_ch.stable_row;
      got.settled = result_ch.settled;
      got.bounce_seen = result_ch.bounce_seen;
      got.ghost = result_ch.ghost;
      sb.check_word(got);
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data = data;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic send_word(input logic [ROW_W-1:0] row, input logic [COL_W-1:0] sample,
                           input logic last);
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      item_ch.valid = 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    item_ch.valid = 1'b1;
    item_ch.row_index = row;
    item_ch.column_sample = sample;
    item_ch.scan_end = last;
    do @(posedge clk); while (!item_ch.ready);
    sb.note_word(row, sample, last);
    @(negedge clk);
  endtask

  task automatic drain;
    item_ch.valid = 1'b0;
    while (sb.due_results.size() != 0) @(posedge clk);
    repeat (2) @(negedge clk);
  endtask

  // mostly sparse patterns, biased to the low columns so that stable rows overlap
  function automatic logic [COL_W-1:0] key_pattern();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return COL_W'(1) << $urandom_range(0, 3);
      2: return (COL_W'(1) << $urandom_range(0, 3)) | (COL_W'(1) << $urandom_range(0, 15));
      default: return COL_W'($urandom) & COL_W'($urandom);
    endcase
  endfunction

  // full scans in row order, with contact bounce, stray words and short scans
  task automatic run_scans(input int n, input int churn);
    int sent;
    int early;
    logic [COL_W-1:0] s;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(0, 99) < churn) keys[$urandom_range(0, ROWS_DEF - 1)] = key_pattern();
      early = ($urandom_range(0, 99) < 3) ? $urandom_range(0, ROWS_DEF - 2) : ROWS_DEF;
      for (int r = 0; r < ROWS_DEF && sent < n; r++) begin
        if ($urandom_range(0, 99) < 2) begin
          send_word(ROW_W'($urandom_range(0, ROWS_DEF - 1)), COL_W'($urandom),
                    1'($urandom_range(0, 1)));
          sent++;
        end
        s = keys[r];
        if ($urandom_range(0, 99) < 2) s = s ^ (COL_W'(1) << $urandom_range(0, 15));
        send_word(ROW_W'(r), s, (r == ROWS_DEF - 1) || (r == early));
        sent++;
        if (r == early) break;
      end
    end
  endtask

  initial begin : stimulus
    rst = 1'b1;
    item_ch.valid = 1'b0;
    item_ch.row_index = '0;
    item_ch.column_sample = '0;
    item_ch.scan_end = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    idle_pct = 0;
    stall_on = 1'b0;
    rx_hold_req = 1'b0;
    foreach (keys[i]) keys[i] = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: extremes, settle, ghosting, scan end at zero and mid scan
    write_reg(REG_RELOAD, 8'd1);
    write_reg(REG_GHOST_EN, 8'd1);
    idle_pct = 20;
    stall_on = 1'b1;
    send_word(3'd0, 16'hFFFF, 1'b0);
    send_word(3'd1, 16'h0003, 1'b0);
    send_word(3'd2, 16'h8001, 1'b0);
    send_word(3'd3, 16'h0000, 1'b0);
    send_word(3'd7, 16'h0002, 1'b1);
    send_word(3'd0, 16'hFFFF, 1'b0);
    send_word(3'd1, 16'h0003, 1'b0);
    send_word(3'd2, 16'h8001, 1'b0);
    send_word(3'd7, 16'h0002, 1'b1);
    send_word(3'd6, 16'h0000, 1'b1);
    send_word(3'd0, 16'h0000, 1'b1);
    send_word(3'd5, 16'h0001, 1'b0);
    send_word(3'd5, 16'h0000, 1'b0);
    send_word(3'd5, 16'h8000, 1'b1);
    send_word(3'd4, 16'h5555, 1'b0);
    send_word(3'd3, 16'hAAAA, 1'b1);
    send_word(3'd4, 16'h5555, 1'b0);
    send_word(3'd3, 16'hAAAA, 1'b1);
    drain();

    write_reg(REG_RELOAD, 8'd2);
    idle_pct = 30;
    run_scans(300, 20);
    drain();

    // reload of zero acts as one, ghost off with upper data bits set
    write_reg(REG_RELOAD, 8'd0);
    write_reg(REG_GHOST_EN, 8'hFE);
    idle_pct = 10;
    stall_on = 1'b0;
    run_scans(250, 25);
    drain();

    write_reg(REG_SPARE_A, CFG_DATA_W'($urandom));
    write_reg(REG_SPARE_B, CFG_DATA_W'($urandom));
    write_reg(REG_RELOAD, 8'd255);
    write_reg(REG_GHOST_EN, 8'h01);
    idle_pct = 0;
    stall_on = 1'b1;
    run_scans(80, 30);
    drain();

    write_reg(REG_RELOAD, 8'd3);
    idle_pct = 25;
    run_scans(100, 15);
    rx_hold_req = 1'b1;
    run_scans(200, 15);
    drain();

    write_reg(REG_RELOAD, CFG_DATA_W'(DEBOUNCE));
    write_reg(REG_GHOST_EN, 8'h00);
    idle_pct = 40;
    run_scans(100, 10);
    drain();
    run_scans(100, 10);
    drain();

    // no idling on either side from here on
    write_reg(REG_RELOAD, 8'd1);
    write_reg(REG_GHOST_EN, 8'h01);
    idle_pct = 0;
    stall_on = 1'b0;
    run_scans(200, 20);
    item_ch.valid = 1'b0;
    while (sb.due_results.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);

    $display("covered %0d words over %0d register writes: %0d bounces, %0d settles, %0d ghosts",
             sb.words, sb.reg_writes, sb.bounces, sb.settles, sb.ghosts);
    if (sb.errors == 0 && sb.due_results.size() == 0) begin
      $display("key_matrix_debounce_unit_test: clean");
    end else begin
      $display("key_matrix_debounce_unit_test: errors");
    end
    $finish;
  end

endmodule

/* sim.f */
src/kmd_pkg.sv
src/kmd_if.sv
src/kmd_row_store.sv
src/kmd_seq.sv
src/key_matrix_debounce_unit.sv
tb/key_matrix_debounce_unit_test.sv
